// ===== rtl/core/face_landmark_geometry_check_macros.svh =====
// ---------------------------------------------------------------------------
// face landmark geometry check assertion macros
// concurrent assertion wrappers, empty when synthesizing
// ---------------------------------------------------------------------------
`ifndef FACE_LANDMARK_GEOMETRY_CHECK_MACROS_SVH
`define FACE_LANDMARK_GEOMETRY_CHECK_MACROS_SVH

`ifndef SYNTHESIS

`define FLGC_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("flgc assertion failed");

`define FLGC_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("flgc implication failed");

`define FLGC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("flgc next-cycle implication failed");

`else

`define FLGC_ASSERT(lbl, clk, rst_n, prop)
`define FLGC_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define FLGC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

// ===== rtl/core/flgc_pkg.sv =====
// ---------------------------------------------------------------------------
// face landmark geometry check package
// coordinate types, register indexes and fixed constants
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package flgc_pkg;

	localparam int FRAC_BITS = 4;
	localparam int LM_COUNT  = 5;
	localparam int MARGIN    = 16 << FRAC_BITS;
	localparam int NET_W     = 12;

	localparam int LM_LEYE   = 0;
	localparam int LM_REYE   = 1;
	localparam int LM_NOSE   = 2;
	localparam int LM_LMOUTH = 3;
	localparam int LM_RMOUTH = 4;

	localparam logic [NET_W-1:0] NET_SIZE_RESET = NET_W'(640);

	typedef logic signed [15:0] coord_t;
	typedef logic signed [16:0] delta_t;
	typedef logic signed [19:0] bound_t;
	typedef logic signed [25:0] sum_t;
	typedef logic [31:0]        sq_t;

	typedef enum logic [1:0] {
		REG_NET_WIDTH  = 2'd0,
		REG_NET_HEIGHT = 2'd1
	} reg_idx_t;

endpackage

`default_nettype wire

// ===== rtl/core/face_landmark_geometry_check.sv =====
// ---------------------------------------------------------------------------
// face landmark geometry check
// pass flag for plausible box and five-landmark face geometry, exact integer
// compares on Q12.4 coordinates through a four-stage pipeline
// ---------------------------------------------------------------------------
// an accepted input word is registered through stages 1, 2, 3 and 4 in turn to its result word
// throughput: 1 word per cycle; four register stages, each with its own valid
// bit and ready, so a stall at the output fills bubbles before holding input
// the widest path is the 17x17 squaring stage and the x10000 compare stage
// reset: all stage valid bits clear, net_width and net_height return to 640
`timescale 1ns / 1ps
`default_nettype none

`include "face_landmark_geometry_check_macros.svh"

module face_landmark_geometry_check (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     cfg_we,
	input  wire logic [1:0]               cfg_index,
	input  wire logic [flgc_pkg::NET_W-1:0] cfg_data,
	input  wire logic                     in_valid,
	output logic                          in_ready,
	input  wire flgc_pkg::coord_t         box_left,
	input  wire flgc_pkg::coord_t         box_top,
	input  wire flgc_pkg::coord_t         box_right,
	input  wire flgc_pkg::coord_t         box_bottom,
	input  wire logic [31:0]              left_eye_xy,
	input  wire logic [31:0]              right_eye_xy,
	input  wire logic [31:0]              nose_xy,
	input  wire logic [31:0]              left_mouth_xy,
	input  wire logic [31:0]              right_mouth_xy,
	output logic                          out_valid,
	input  wire logic                     out_ready,
	output logic                          face_valid
);

	import flgc_pkg::*;

	logic [NET_W-1:0] net_width_q;
	logic [NET_W-1:0] net_height_q;

	// handshake
	logic v_s1, v_s2, v_s3, v_s4;
	logic rdy1, rdy2, rdy3, rdy4;

	// stage 0 decode
	logic [31:0] lm_xy [LM_COUNT];
	coord_t      lx [LM_COUNT];
	coord_t      ly [LM_COUNT];

	// stage 1
	delta_t w_s1, h_s1;
	bound_t bxlo_s1, bxhi_s1, bylo_s1, byhi_s1;
	coord_t lx_s1 [LM_COUNT];
	coord_t ly_s1 [LM_COUNT];
	delta_t edx_s1, edy_s1, mdx_s1, mdy_s1;
	delta_t esum_s1, msum_s1;
	coord_t exmin_s1, exmax_s1;

	// stage 2
	logic ok_s2;
	sq_t  sq_edx_s2, sq_edy_s2, sq_mdx_s2, sq_mdy_s2, w2_s2;

	// stage 3
	logic        ok_s3;
	logic [32:0] e2_s3, m2_s3;
	logic [39:0] w144_s3;
	logic [37:0] w64_s3;
	logic [35:0] w9_s3;

	// stage 4
	logic ok_s4;

	// stage 2 logic
	logic signed [17:0] fxhi, fyhi;
	logic               lm_ok;
	logic               ok_c2;
	sum_t               w_w, h_w, esum_w, msum_w, nx_w, ny_w;
	logic signed [33:0] p_edx, p_edy, p_mdx, p_mdy, p_w;

	// stage 4 logic
	logic        ok_c4;
	logic [47:0] e2k, m2k;

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			net_width_q  <= NET_SIZE_RESET;
			net_height_q <= NET_SIZE_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_NET_WIDTH:  net_width_q  <= cfg_data;
				REG_NET_HEIGHT: net_height_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// per-stage ready chain
	assign rdy4     = !v_s4 || out_ready;
	assign rdy3     = !v_s3 || rdy4;
	assign rdy2     = !v_s2 || rdy3;
	assign rdy1     = !v_s1 || rdy2;
	assign in_ready = rdy1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (rdy1) v_s1 <= in_valid;
			if (rdy2) v_s2 <= v_s1;
			if (rdy3) v_s3 <= v_s2;
			if (rdy4) v_s4 <= v_s3;
		end
	end

	// stage 0: unpack landmarks
	always_comb begin
		lm_xy[LM_LEYE]   = left_eye_xy;
		lm_xy[LM_REYE]   = right_eye_xy;
		lm_xy[LM_NOSE]   = nose_xy;
		lm_xy[LM_LMOUTH] = left_mouth_xy;
		lm_xy[LM_RMOUTH] = right_mouth_xy;
		for (int i = 0; i < LM_COUNT; i++) begin
			lx[i] = coord_t'(lm_xy[i][31:16]);
			ly[i] = coord_t'(lm_xy[i][15:0]);
		end
	end

	// stage 1: box size, widened bounds, landmark differences
	always_ff @(posedge clk) begin
		if (rdy1 && in_valid) begin
			w_s1    <= delta_t'(box_right) - delta_t'(box_left);
			h_s1    <= delta_t'(box_bottom) - delta_t'(box_top);
			bxlo_s1 <= bound_t'(5) * bound_t'(box_left) - bound_t'(box_right);
			bxhi_s1 <= bound_t'(5) * bound_t'(box_right) - bound_t'(box_left);
			bylo_s1 <= bound_t'(5) * bound_t'(box_top) - bound_t'(box_bottom);
			byhi_s1 <= bound_t'(5) * bound_t'(box_bottom) - bound_t'(box_top);
			for (int i = 0; i < LM_COUNT; i++) begin
				lx_s1[i] <= lx[i];
				ly_s1[i] <= ly[i];
			end
			edx_s1   <= delta_t'(lx[LM_REYE]) - delta_t'(lx[LM_LEYE]);
			edy_s1   <= delta_t'(ly[LM_REYE]) - delta_t'(ly[LM_LEYE]);
			mdx_s1   <= delta_t'(lx[LM_RMOUTH]) - delta_t'(lx[LM_LMOUTH]);
			mdy_s1   <= delta_t'(ly[LM_RMOUTH]) - delta_t'(ly[LM_LMOUTH]);
			esum_s1  <= delta_t'(ly[LM_LEYE]) + delta_t'(ly[LM_REYE]);
			msum_s1  <= delta_t'(ly[LM_LMOUTH]) + delta_t'(ly[LM_RMOUTH]);
			exmin_s1 <= (lx[LM_LEYE] < lx[LM_REYE]) ? lx[LM_LEYE] : lx[LM_REYE];
			exmax_s1 <= (lx[LM_LEYE] < lx[LM_REYE]) ? lx[LM_REYE] : lx[LM_LEYE];
		end
	end

	// stage 2: linear checks and squares
	assign fxhi = $signed({2'b00, net_width_q, FRAC_BITS'(0)}) + 18'(MARGIN);
	assign fyhi = $signed({2'b00, net_height_q, FRAC_BITS'(0)}) + 18'(MARGIN);

	assign w_w    = sum_t'(w_s1);
	assign h_w    = sum_t'(h_s1);
	assign esum_w = sum_t'(esum_s1);
	assign msum_w = sum_t'(msum_s1);
	assign nx_w   = sum_t'(lx_s1[LM_NOSE]);
	assign ny_w   = sum_t'(ly_s1[LM_NOSE]);

	always_comb begin
		lm_ok = 1'b1;
		for (int i = 0; i < LM_COUNT; i++) begin
			if (bound_t'(4) * bound_t'(lx_s1[i]) < bxlo_s1 ||
			    bound_t'(4) * bound_t'(lx_s1[i]) > bxhi_s1 ||
			    bound_t'(4) * bound_t'(ly_s1[i]) < bylo_s1 ||
			    bound_t'(4) * bound_t'(ly_s1[i]) > byhi_s1)
				lm_ok = 1'b0;
			if (18'(lx_s1[i]) < -18'(MARGIN) || 18'(lx_s1[i]) > fxhi ||
			    18'(ly_s1[i]) < -18'(MARGIN) || 18'(ly_s1[i]) > fyhi)
				lm_ok = 1'b0;
		end
	end

	always_comb begin
		ok_c2 = lm_ok
			&& (w_s1 > delta_t'(0)) && (h_s1 > delta_t'(0))
			&& (sum_t'(100) * w_w >= sum_t'(45) * h_w)
			&& (sum_t'(100) * w_w <= sum_t'(145) * h_w)
			&& (edx_s1 > delta_t'(0)) && (mdx_s1 > delta_t'(0))
			&& (sum_t'(200) * ny_w > sum_t'(100) * esum_w - sum_t'(30) * h_w)
			&& (sum_t'(4) * ny_w < sum_t'(2) * msum_w + h_w)
			&& (sum_t'(5) * (msum_w - esum_w) > h_w)
			&& (sum_t'(20) * nx_w >= sum_t'(20) * sum_t'(exmin_s1) - sum_t'(7) * w_w)
			&& (sum_t'(20) * nx_w <= sum_t'(20) * sum_t'(exmax_s1) + sum_t'(7) * w_w);
	end

	assign p_edx = 34'(edx_s1) * 34'(edx_s1);
	assign p_edy = 34'(edy_s1) * 34'(edy_s1);
	assign p_mdx = 34'(mdx_s1) * 34'(mdx_s1);
	assign p_mdy = 34'(mdy_s1) * 34'(mdy_s1);
	assign p_w   = 34'(w_s1) * 34'(w_s1);

	always_ff @(posedge clk) begin
		if (rdy2 && v_s1) begin
			ok_s2     <= ok_c2;
			sq_edx_s2 <= p_edx[31:0];
			sq_edy_s2 <= p_edy[31:0];
			sq_mdx_s2 <= p_mdx[31:0];
			sq_mdy_s2 <= p_mdy[31:0];
			w2_s2     <= p_w[31:0];
		end
	end

	// stage 3: squared spans and scaled width bounds
	always_ff @(posedge clk) begin
		if (rdy3 && v_s2) begin
			ok_s3   <= ok_s2;
			e2_s3   <= {1'b0, sq_edx_s2} + {1'b0, sq_edy_s2};
			m2_s3   <= {1'b0, sq_mdx_s2} + {1'b0, sq_mdy_s2};
			w144_s3 <= 40'(w2_s2) * 40'd144;
			w64_s3  <= {w2_s2, 6'b0};
			w9_s3   <= 36'(w2_s2) * 36'd9;
		end
	end

	// stage 4: span band compares, result word
	assign e2k = 48'(e2_s3) * 48'd10000;
	assign m2k = 48'(m2_s3) * 48'd10000;

	always_comb begin
		ok_c4 = ok_s3
			&& (e2k >= 48'(w144_s3))
			&& ({e2_s3, 4'b0} <= 37'(w9_s3))
			&& (m2k >= 48'(w64_s3))
			&& ({m2_s3, 4'b0} <= 37'(w9_s3));
	end

	always_ff @(posedge clk) begin
		if (rdy4 && v_s3)
			ok_s4 <= ok_c4;
	end

	assign out_valid  = v_s4;
	assign face_valid = ok_s4;

	// checks
	`FLGC_ASSERT_IMP(a_ready_follows_out, clk, arst_n, out_ready, in_ready)
	`FLGC_ASSERT_NEXT(a_accept_fills_s1, clk, arst_n, in_valid && in_ready, v_s1)
	`FLGC_ASSERT_NEXT(a_s3_moves_to_out, clk, arst_n, v_s3 && rdy4, out_valid)

endmodule

`default_nettype wire

// ===== tb/testbench.sv =====
// ---------------------------------------------------------------------------
// face landmark geometry check testbench
// drives box and landmark words through a queue-fed driver under random
// idling and back-pressure, predicts each pass flag on integers and compares
// it with the result word; frame size registers are swept between phases
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
	import flgc_pkg::*;

	localparam logic [1:0] REG_SPARE_LO = 2'd2;
	localparam logic [1:0] REG_SPARE_HI = 2'd3;
	localparam int PHASES = 7;
	localparam int RANDOM_PER_PHASE = 200;

	typedef struct packed {
		coord_t                       left;
		coord_t                       top;
		coord_t                       right;
		coord_t                       bottom;
		logic [LM_COUNT-1:0][31:0]    lm;
	} face_t;

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             cfg_we = 1'b0;
	logic [1:0]       cfg_index = 2'd0;
	logic [NET_W-1:0] cfg_data = '0;
	logic             in_valid = 1'b0;
	logic             in_ready;
	logic             out_valid;
	logic             out_ready = 1'b0;
	logic             face_valid;
	face_t            drv_face = '0;

	face_t            pending_faces [$];
	bit               expected_flags [$];
	logic [NET_W-1:0] frame_w = NET_SIZE_RESET;
	logic [NET_W-1:0] frame_h = NET_SIZE_RESET;
	int               in_gap = 0;
	int               out_gap = 0;
	int               hold_cnt = 0;
	int               words_in = 0;
	int               words_out = 0;
	int               mismatches = 0;

	face_landmark_geometry_check u_top (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.box_left       (drv_face.left),
		.box_top        (drv_face.top),
		.box_right      (drv_face.right),
		.box_bottom     (drv_face.bottom),
		.left_eye_xy    (drv_face.lm[LM_LEYE]),
		.right_eye_xy   (drv_face.lm[LM_REYE]),
		.nose_xy        (drv_face.lm[LM_NOSE]),
		.left_mouth_xy  (drv_face.lm[LM_LMOUTH]),
		.right_mouth_xy (drv_face.lm[LM_RMOUTH]),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.face_valid     (face_valid)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic int pick(int lo, int hi);
		return int'($urandom_range(hi, lo));
	endfunction

	function automatic int idle_len(bit quiet);
		int r;
		if (quiet)
			return 0;
		r = pick(0, 99);
		if (r < 60)
			return 0;
		if (r < 92)
			return pick(1, 3);
		return pick(6, 25);
	endfunction

	function automatic void add_face(face_t f);
		pending_faces.insert(pending_faces.size(), f);
	endfunction

	function automatic bit face_geometry_ok(face_t f, logic [NET_W-1:0] nw,
			logic [NET_W-1:0] nh);
		longint l, t, r, b, w, h, fw, fh, mg, x, y;
		longint px [LM_COUNT];
		longint py [LM_COUNT];
		longint edx, edy, mdx, mdy, e2, m2, w2, esum, msum, exmin, exmax;
		l = f.left;
		t = f.top;
		r = f.right;
		b = f.bottom;
		w = r - l;
		h = b - t;
		fw = longint'(nw) << FRAC_BITS;
		fh = longint'(nh) << FRAC_BITS;
		mg = MARGIN;
		for (int i = 0; i < LM_COUNT; i++) begin
			px[i] = $signed(f.lm[i][31:16]);
			py[i] = $signed(f.lm[i][15:0]);
		end
		if (w <= 0 || h <= 0)
			return 1'b0;
		if (100 * w < 45 * h || 100 * w > 145 * h)
			return 1'b0;
		for (int i = 0; i < LM_COUNT; i++) begin
			x = px[i];
			y = py[i];
			if (4 * x < 4 * l - w || 4 * x > 4 * r + w)
				return 1'b0;
			if (4 * y < 4 * t - h || 4 * y > 4 * b + h)
				return 1'b0;
			if (x < -mg || x > fw + mg || y < -mg || y > fh + mg)
				return 1'b0;
		end
		edx = px[LM_REYE] - px[LM_LEYE];
		edy = py[LM_REYE] - py[LM_LEYE];
		mdx = px[LM_RMOUTH] - px[LM_LMOUTH];
		mdy = py[LM_RMOUTH] - py[LM_LMOUTH];
		if (edx <= 0 || mdx <= 0)
			return 1'b0;
		e2 = edx * edx + edy * edy;
		m2 = mdx * mdx + mdy * mdy;
		w2 = w * w;
		if (10000 * e2 < 144 * w2 || 16 * e2 > 9 * w2)
			return 1'b0;
		if (10000 * m2 < 64 * w2 || 16 * m2 > 9 * w2)
			return 1'b0;
		esum = py[LM_LEYE] + py[LM_REYE];
		msum = py[LM_LMOUTH] + py[LM_RMOUTH];
		// nose below eye line less 0.15h, above mouth line plus 0.25h
		if (200 * py[LM_NOSE] <= 100 * esum - 30 * h)
			return 1'b0;
		if (4 * py[LM_NOSE] >= 2 * msum + h)
			return 1'b0;
		if (5 * (msum - esum) <= h)
			return 1'b0;
		exmin = (px[LM_LEYE] < px[LM_REYE]) ? px[LM_LEYE] : px[LM_REYE];
		exmax = (px[LM_LEYE] < px[LM_REYE]) ? px[LM_REYE] : px[LM_LEYE];
		if (20 * px[LM_NOSE] < 20 * exmin - 7 * w || 20 * px[LM_NOSE] > 20 * exmax + 7 * w)
			return 1'b0;
		return 1'b1;
	endfunction

	function automatic logic [31:0] pack_xy(int x, int y);
		return {x[15:0], y[15:0]};
	endfunction

	function automatic face_t make_face(int l, int t, int w, int h);
		face_t f;
		f.left   = coord_t'(l);
		f.top    = coord_t'(t);
		f.right  = coord_t'(l + w);
		f.bottom = coord_t'(t + h);
		f.lm[LM_LEYE]   = pack_xy(l + w * 30 / 100, t + h * 40 / 100);
		f.lm[LM_REYE]   = pack_xy(l + w * 70 / 100, t + h * 40 / 100);
		f.lm[LM_NOSE]   = pack_xy(l + w * 50 / 100, t + h * 60 / 100);
		f.lm[LM_LMOUTH] = pack_xy(l + w * 35 / 100, t + h * 80 / 100);
		f.lm[LM_RMOUTH] = pack_xy(l + w * 65 / 100, t + h * 80 / 100);
		return f;
	endfunction

	function automatic face_t random_face(logic [NET_W-1:0] nw, logic [NET_W-1:0] nh);
		int fw, fh, wmax, w, h, span, l, t;
		face_t f;
		fw = int'(nw) * 16;
		fh = int'(nh) * 16;
		wmax = fw + 256;
		if (wmax > 6000)
			wmax = 6000;
		if (wmax < 64)
			wmax = 64;
		w = pick(32, wmax);
		h = w * 100 / pick(40, 150);
		if (h < 1)
			h = 1;
		span = fw + 512 - w;
		if (span < 0)
			span = 0;
		l = pick(0, span) - 256;
		span = fh + 512 - h;
		if (span < 0)
			span = 0;
		t = pick(0, span) - 256;
		f.left   = coord_t'(l);
		f.top    = coord_t'(t);
		f.right  = coord_t'(l + w);
		f.bottom = coord_t'(t + h);
		f.lm[LM_LEYE]   = pack_xy(l + w * pick(15, 40) / 100, t + h * pick(25, 45) / 100);
		f.lm[LM_REYE]   = pack_xy(l + w * pick(60, 85) / 100, t + h * pick(25, 45) / 100);
		f.lm[LM_NOSE]   = pack_xy(l + w * pick(30, 70) / 100, t + h * pick(45, 70) / 100);
		f.lm[LM_LMOUTH] = pack_xy(l + w * pick(15, 45) / 100, t + h * pick(70, 95) / 100);
		f.lm[LM_RMOUTH] = pack_xy(l + w * pick(55, 85) / 100, t + h * pick(70, 95) / 100);
		return f;
	endfunction

	// small offset on one coordinate, lands near the compare thresholds
	function automatic face_t nudge(face_t f);
		int k;
		coord_t d;
		k = pick(0, 13);
		d = coord_t'(pick(0, 12) - 6);
		case (k)
			0: f.left = f.left + d;
			1: f.top = f.top + d;
			2: f.right = f.right + d;
			3: f.bottom = f.bottom + d;
			default: begin
				if (k % 2 == 0)
					f.lm[(k - 4) / 2][31:16] = f.lm[(k - 4) / 2][31:16] + d;
				else
					f.lm[(k - 4) / 2][15:0] = f.lm[(k - 4) / 2][15:0] + d;
			end
		endcase
		return f;
	endfunction

	task automatic write_reg(logic [1:0] idx, logic [NET_W-1:0] val);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == REG_NET_WIDTH)
			frame_w = val;
		else if (idx == REG_NET_HEIGHT)
			frame_h = val;
	endtask

	// sampled mid-cycle so the driver's updates at the edge have settled
	task automatic drain();
		while (pending_faces.size() != 0 || in_valid || expected_flags.size() != 0)
			@(negedge clk);
		repeat (8) @(posedge clk);
	endtask

	// input driver
	always @(posedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && in_ready) begin
				expected_flags.insert(expected_flags.size(),
					face_geometry_ok(drv_face, frame_w, frame_h));
				words_in++;
			end
			if (!in_valid || in_ready) begin
				if (in_gap > 0) begin
					in_gap--;
					in_valid <= 1'b0;
				end else if (pending_faces.size() != 0) begin
					drv_face <= pending_faces.pop_front();
					in_valid <= 1'b1;
					in_gap = idle_len(((words_in / 160) % 4) == 2);
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// result monitor
	always @(posedge clk) begin
		bit exp_flag;
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				if (expected_flags.size() == 0) begin
					$error("unexpected result word: face_valid actual %0b", face_valid);
					mismatches++;
				end else begin
					exp_flag = expected_flags.pop_front();
					if (face_valid !== exp_flag) begin
						$error("face_valid mismatch: expected %0b actual %0b",
							exp_flag, face_valid);
						mismatches++;
					end
				end
				words_out++;
				if (words_out == 300 || words_out == 1000)
					hold_cnt = 80;
			end
			if (hold_cnt > 0) begin
				hold_cnt--;
				out_ready <= 1'b0;
			end else if (out_gap > 0) begin
				out_gap--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
				out_gap = idle_len(((words_out / 160) % 4) == 0);
			end
		end
	end

	initial begin
		#5_000_000;
		$display("CHECKS FAILED");
		$finish;
	end

	initial begin
		face_t f;
		int r;
		int phase_w [PHASES];
		int phase_h [PHASES];
		phase_w = '{640, 4095, 1, 0, 320, 0, 4095};
		phase_h = '{640, 4095, 1, 0, 4095, 0, 1};
		phase_w[5] = pick(1, 4095);
		phase_h[5] = pick(1, 4095);

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		f = make_face(1600, 1600, 1600, 1600);
		add_face(f);
		add_face('0);
		f.left = 16'h7fff; f.top = 16'h7fff; f.right = 16'h7fff; f.bottom = 16'h7fff;
		f.lm = '1;
		add_face(f);
		f.left = 16'h8000; f.top = 16'h8000; f.right = 16'h8000; f.bottom = 16'h8000;
		f.lm = {LM_COUNT{32'h8000_8000}};
		add_face(f);
		// inverted and empty boxes
		add_face(make_face(3200, 1600, -1600, 1600));
		add_face(make_face(1600, 1600, 1600, 0));
		// aspect limits
		add_face(make_face(1600, 1600, 720, 1600));
		add_face(make_face(1600, 1600, 719, 1600));
		add_face(make_face(1600, 1600, 2320, 1600));
		add_face(make_face(1600, 1600, 2321, 1600));
		// eyes on the top edge of the widened box
		f = make_face(1600, 1600, 1600, 1600);
		f.lm[LM_LEYE][15:0] = 16'sd1200;
		f.lm[LM_REYE][15:0] = 16'sd1200;
		add_face(f);
		f.lm[LM_LEYE][15:0] = 16'sd1199;
		add_face(f);
		// eyes on the frame margin
		f = make_face(1600, 0, 1600, 1600);
		f.lm[LM_LEYE][15:0] = -16'sd256;
		f.lm[LM_REYE][15:0] = -16'sd256;
		add_face(f);
		f.lm[LM_REYE][15:0] = -16'sd257;
		add_face(f);
		// equal x for eyes and for mouth corners
		f = make_face(1600, 1600, 1600, 1600);
		f.lm[LM_REYE][31:16] = f.lm[LM_LEYE][31:16];
		add_face(f);
		f = make_face(1600, 1600, 1600, 1600);
		f.lm[LM_RMOUTH][31:16] = f.lm[LM_LMOUTH][31:16];
		add_face(f);
		// mouth just 0.10h below the eyes
		f = make_face(1600, 1600, 1600, 1600);
		f.lm[LM_LEYE][15:0] = 16'sd2720;
		f.lm[LM_REYE][15:0] = 16'sd2720;
		add_face(f);
		f.lm[LM_LEYE][15:0] = 16'sd2719;
		f.lm[LM_REYE][15:0] = 16'sd2719;
		add_face(f);
		// nose on the eye line limit
		f = make_face(1600, 1600, 1600, 1600);
		f.lm[LM_NOSE][15:0] = 16'sd2000;
		add_face(f);
		f.lm[LM_NOSE][15:0] = 16'sd2001;
		add_face(f);
		// nose x on the left limit
		f = make_face(1600, 1600, 1600, 1600);
		f.lm[LM_NOSE][31:16] = 16'sd1520;
		add_face(f);
		f.lm[LM_NOSE][31:16] = 16'sd1519;
		add_face(f);
		// minimum eye span
		f = make_face(1600, 1600, 1600, 1600);
		f.lm[LM_REYE][31:16] = 16'sd2272;
		add_face(f);
		f.lm[LM_REYE][31:16] = 16'sd2271;
		add_face(f);

		for (int p = 0; p < PHASES; p++) begin
			if (p > 0) begin
				drain();
				write_reg(REG_NET_WIDTH, NET_W'(phase_w[p]));
				write_reg(REG_NET_HEIGHT, NET_W'(phase_h[p]));
				write_reg((p % 2 == 0) ? REG_SPARE_LO : REG_SPARE_HI, NET_W'($urandom));
			end
			for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
				r = pick(0, 99);
				if (r < 15) begin
					f.left = coord_t'($urandom); f.top = coord_t'($urandom);
					f.right = coord_t'($urandom); f.bottom = coord_t'($urandom);
					for (int k = 0; k < LM_COUNT; k++)
						f.lm[k] = $urandom;
				end else if (r < 45) begin
					f = nudge(random_face(frame_w, frame_h));
				end else begin
					f = random_face(frame_w, frame_h);
				end
				add_face(f);
			end
		end

		drain();
		repeat (12) @(posedge clk);
		if (mismatches == 0 && expected_flags.size() == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
